/* hw/rtl/mfct_pkg.sv */
// ----------------------------------------------------------------------------
// mfct_pkg: shared types and constants for the mirror field transform
// Fixed-point formats, item record of the pipeline, multiply helpers.
// ----------------------------------------------------------------------------
package mfct_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 24;
  localparam int VEC_PRESHIFT  = 16;

  localparam int PW  = 63;                 // product magnitude width (cap is 2^62)
  localparam int CW  = 52;                 // CORDIC x/y width, signed
  localparam int ZW  = 34;                 // CORDIC angle width, signed
  localparam int DVW = 31;                 // divisor width
  localparam int NW  = DVW + FRAC_BITS;    // dividend / quotient width

  localparam logic [PW-1:0] CAP       = PW'(1) << 62;
  localparam logic [PW-1:0] ONE       = PW'(1) << FRAC_BITS;
  localparam logic [31:0]   INV_SQRT3 = 32'd2479700524;
  localparam logic [PW-1:0] HALF_PI   = PW'(1686629713);

  localparam logic [5:0] SH_FRAC  = 6'(FRAC_BITS);
  localparam logic [5:0] SH_TAN   = 6'(FRAC_BITS + 2);
  localparam logic [5:0] SH_ANGLE = 6'd30;
  localparam logic [5:0] SH_WORD  = 6'd32;

  localparam logic CMD_FWD = 1'b0;
  localparam logic CMD_INV = 1'b1;

  localparam logic [2:0] REG_MIRROR_XI        = 3'd0;
  localparam logic [2:0] REG_GRID_D1          = 3'd1;
  localparam logic [2:0] REG_INVERSE_XI       = 3'd2;
  localparam logic [2:0] REG_INVERSE_D1       = 3'd3;
  localparam logic [2:0] REG_SERIES_THRESHOLD = 3'd4;

  localparam logic [29:0] ANGLE_TAB [0:9] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149
  };

  typedef struct packed {
    logic [63:0] ll;
    logic [63:0] lh;
    logic [63:0] hl;
    logic [63:0] hh;
  } pp_t;

  typedef struct packed {
    logic          ovf;
    logic [PW-1:0] val;
  } mres_t;

  typedef struct packed {
    logic                 cmd;
    logic                 ser;
    logic                 neg;
    logic                 flip;
    logic                 ovf;
    logic [31:0]          mag;
    logic [PW-1:0]        a;
    logic [PW-1:0]        t;
    logic [PW-1:0]        v;
    logic [PW-1:0]        u2;
    logic [PW-1:0]        fac;
    logic [PW-1:0]        p;
    logic [PW-1:0]        r;
    pp_t                  pp;
    logic [5:0]           sh;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [ZW-1:0] cz;
    logic [31:0]          zc;
    logic [DVW-1:0]       rem;
    logic [NW-1:0]        num;
    logic [NW-1:0]        quo;
    logic [DVW-1:0]       dvs;
    logic [31:0]          res;
    logic                 err;
  } item_t;

  // 32x32 partial products of two magnitudes
  function automatic pp_t mul_pp(input logic [PW-1:0] a, input logic [PW-1:0] b);
    pp_t         r;
    logic [63:0] al, ah, bl, bh;
    al = 64'(a[31:0]);
    ah = 64'(a[PW-1:32]);
    bl = 64'(b[31:0]);
    bh = 64'(b[PW-1:32]);
    r.ll = al * bl;
    r.lh = al * bh;
    r.hl = ah * bl;
    r.hh = ah * bh;
    return r;
  endfunction

  // sum partials, shift right, cap at 2^62 with overflow flag
  function automatic mres_t mul_fin(input pp_t pp, input logic [5:0] sh);
    mres_t        r;
    logic [127:0] prod, sr;
    prod = {64'b0, pp.ll} + {32'b0, pp.lh, 32'b0} + {32'b0, pp.hl, 32'b0} + {pp.hh, 64'b0};
    sr = prod >> sh;
    r.ovf = (sr > 128'(CAP));
    r.val = r.ovf ? CAP : sr[PW-1:0];
    return r;
  endfunction

  function automatic logic [ZW-1:0] cordic_angle(input int i);
    if (i < 10) begin
      return ZW'(ANGLE_TAB[i[3:0]]);
    end else if (i <= 30) begin
      return ZW'(1) << (30 - i);
    end
    return '0;
  endfunction

endpackage

/* hw/rtl/mirror_field_coordinate_transform.sv */
// ----------------------------------------------------------------------------
// mirror_field_coordinate_transform: Cartesian <-> curvilinear mapping
// Series or CORDIC/divider path per item, saturating signed Q16.16 output.
// ----------------------------------------------------------------------------
// Pipeline: 87 register stages, set by the 24 CORDIC stages and the 47-stage
// radix-2 divider plus six two-stage multiplies.
// Throughput: one request per cycle; the whole pipeline holds while the
// output register is full and not taken.
// Reset: pipeline emptied, configuration registers back to their defaults.
// ----------------------------------------------------------------------------
module mirror_field_coordinate_transform (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // [31:0] coord_in
  input  logic [0:0]  s_tuser,    // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [31:0] coord_out
  output logic [0:0]  m_tuser,    // [0] range_error
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int ST_IN   = 0;
  localparam int ST_M0   = 1;
  localparam int ST_M1   = 3;
  localparam int ST_M2   = 5;
  localparam int ST_M3   = 7;
  localparam int ST_PREP = 9;
  localparam int ST_CRD  = 10;
  localparam int ST_POST = ST_CRD + mfct_pkg::CORDIC_STAGES;
  localparam int ST_DIV  = ST_POST + 1;
  localparam int ST_M4   = ST_DIV + mfct_pkg::NW;
  localparam int ST_M5   = ST_M4 + 2;
  localparam int ST_OUT  = ST_M5 + 2;
  localparam int NST     = ST_OUT + 1;

  logic [31:0] mirror_xi, grid_d1, inverse_xi, inverse_d1, series_threshold;

  mfct_pkg::item_t st [NST];
  mfct_pkg::item_t nx [NST];
  logic [NST-1:0]  vld;
  logic            en;

  assign en        = ~vld[NST-1] | m_tready;
  assign s_tready  = en;
  assign m_tvalid  = vld[NST-1];
  assign m_tdata   = st[NST-1].res;
  assign m_tuser   = st[NST-1].err;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mirror_xi        <= '0;
      grid_d1          <= 32'(1) << mfct_pkg::FRAC_BITS;
      inverse_xi       <= '0;
      inverse_d1       <= 32'(1) << mfct_pkg::FRAC_BITS;
      series_threshold <= 32'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        mfct_pkg::REG_MIRROR_XI:        mirror_xi        <= cfg_data;
        mfct_pkg::REG_GRID_D1:          grid_d1          <= cfg_data;
        mfct_pkg::REG_INVERSE_XI:       inverse_xi       <= cfg_data;
        mfct_pkg::REG_INVERSE_D1:       inverse_d1       <= cfg_data;
        mfct_pkg::REG_SERIES_THRESHOLD: series_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], s_tvalid};
    end
    if (en) begin
      for (int i = 0; i < NST; i++) begin
        st[i] <= nx[i];
      end
    end
  end

  always_comb begin : c_pipe
    mfct_pkg::mres_t           mr;
    mfct_pkg::item_t           s;
    logic                      vec, pos, sdir;
    logic signed [mfct_pkg::CW-1:0] xs, ys;
    logic [mfct_pkg::ZW-1:0]   ang;
    logic [mfct_pkg::DVW:0]    rm;
    logic [mfct_pkg::PW-1:0]   lim;
    logic                      ng;

    // input decode: work on magnitude, sign applied at the end
    nx[ST_IN]     = '0;
    nx[ST_IN].cmd = s_tuser[0];
    nx[ST_IN].neg = s_tdata[31];
    nx[ST_IN].mag = s_tdata[31] ? (32'(0) - s_tdata) : s_tdata;
    nx[ST_IN].ser = (mirror_xi < series_threshold);

    // a = mag * (cmd ? D1 : 1.0)
    nx[ST_M0]    = st[ST_M0-1];
    nx[ST_M0].pp = mfct_pkg::mul_pp(mfct_pkg::PW'(st[ST_M0-1].mag),
                     (st[ST_M0-1].cmd == mfct_pkg::CMD_INV) ?
                     mfct_pkg::PW'(grid_d1) : mfct_pkg::ONE);
    nx[ST_M0].sh = mfct_pkg::SH_FRAC;
    nx[ST_M0+1]     = st[ST_M0];
    mr              = mfct_pkg::mul_fin(st[ST_M0].pp, st[ST_M0].sh);
    nx[ST_M0+1].a   = mr.val;
    nx[ST_M0+1].ovf = st[ST_M0].ovf | mr.ovf;

    // t = a * xi (series term or tangent argument)
    nx[ST_M1]    = st[ST_M1-1];
    nx[ST_M1].pp = mfct_pkg::mul_pp(st[ST_M1-1].a, mfct_pkg::PW'(mirror_xi));
    nx[ST_M1].sh = (st[ST_M1-1].cmd == mfct_pkg::CMD_INV && !st[ST_M1-1].ser) ?
                   mfct_pkg::SH_TAN : mfct_pkg::SH_WORD;
    nx[ST_M1+1]     = st[ST_M1];
    mr              = mfct_pkg::mul_fin(st[ST_M1].pp, st[ST_M1].sh);
    nx[ST_M1+1].t   = mr.val;
    nx[ST_M1+1].ovf = st[ST_M1].ovf | mr.ovf;

    // v = t / sqrt(3)
    nx[ST_M2]    = st[ST_M2-1];
    nx[ST_M2].pp = mfct_pkg::mul_pp(st[ST_M2-1].t, mfct_pkg::PW'(mfct_pkg::INV_SQRT3));
    nx[ST_M2].sh = mfct_pkg::SH_WORD;
    nx[ST_M2+1]     = st[ST_M2];
    mr              = mfct_pkg::mul_fin(st[ST_M2].pp, st[ST_M2].sh);
    nx[ST_M2+1].v   = mr.val;
    nx[ST_M2+1].ovf = st[ST_M2].ovf | (st[ST_M2].ser & mr.ovf);

    // u2 = v * v
    nx[ST_M3]    = st[ST_M3-1];
    nx[ST_M3].pp = mfct_pkg::mul_pp(st[ST_M3-1].v, st[ST_M3-1].v);
    nx[ST_M3].sh = mfct_pkg::SH_FRAC;
    nx[ST_M3+1]     = st[ST_M3];
    mr              = mfct_pkg::mul_fin(st[ST_M3].pp, st[ST_M3].sh);
    nx[ST_M3+1].u2  = mr.val;
    nx[ST_M3+1].ovf = st[ST_M3].ovf | (st[ST_M3].ser & mr.ovf);

    // series factor and CORDIC start values
    s = st[ST_PREP-1];
    if (s.u2 > mfct_pkg::ONE) begin
      s.fac  = s.u2 - mfct_pkg::ONE;
      s.flip = (s.cmd == mfct_pkg::CMD_FWD) && s.ser;
    end else begin
      s.fac = mfct_pkg::ONE - s.u2;
    end
    if (s.cmd == mfct_pkg::CMD_FWD) begin
      s.cx = mfct_pkg::CW'(1) << (mfct_pkg::FRAC_BITS + mfct_pkg::VEC_PRESHIFT);
      s.cy = mfct_pkg::CW'(s.t[31:0]) << mfct_pkg::VEC_PRESHIFT;
      s.cz = '0;
    end else begin
      s.cx = mfct_pkg::CW'(1) << 30;
      s.cy = '0;
      s.cz = mfct_pkg::ZW'(s.t[31:0]);
      if (!s.ser && s.t >= mfct_pkg::HALF_PI) begin
        s.ovf = 1'b1;
      end
    end
    nx[ST_PREP] = s;

    // CORDIC: vectoring for arctangent, rotation for tangent
    for (int k = 0; k < mfct_pkg::CORDIC_STAGES; k++) begin
      s    = st[ST_CRD+k-1];
      vec  = (s.cmd == mfct_pkg::CMD_FWD);
      pos  = vec ? ~s.cy[mfct_pkg::CW-1] : ~s.cz[mfct_pkg::ZW-1];
      sdir = vec ? pos : ~pos;
      xs   = s.cx >>> k;
      ys   = s.cy >>> k;
      ang  = mfct_pkg::cordic_angle(k);
      if (sdir) begin
        s.cx = s.cx + ys;
        s.cy = s.cy - xs;
        s.cz = s.cz + $signed(ang);
      end else begin
        s.cx = s.cx - ys;
        s.cy = s.cy + xs;
        s.cz = s.cz - $signed(ang);
      end
      nx[ST_CRD+k] = s;
    end

    // clamp residues, set up tan = y / x
    s    = st[ST_POST-1];
    s.zc = s.cz[mfct_pkg::ZW-1] ? 32'd0 : s.cz[31:0];
    if (s.cmd == mfct_pkg::CMD_INV && !s.ser &&
        (s.cx[mfct_pkg::CW-1] || s.cx == '0)) begin
      s.ovf = 1'b1;
    end
    s.dvs = (s.cx[mfct_pkg::CW-1] || s.cx == '0) ? mfct_pkg::DVW'(1) :
            s.cx[mfct_pkg::DVW-1:0];
    s.num = s.cy[mfct_pkg::CW-1] ? '0 :
            {s.cy[mfct_pkg::DVW-1:0], mfct_pkg::FRAC_BITS'(0)};
    s.rem = '0;
    s.quo = '0;
    nx[ST_POST] = s;

    // restoring divider, one quotient bit per stage
    for (int k = 0; k < mfct_pkg::NW; k++) begin
      s     = st[ST_DIV+k-1];
      rm    = {s.rem, s.num[mfct_pkg::NW-1]};
      s.num = s.num << 1;
      if (rm >= {1'b0, s.dvs}) begin
        s.rem = mfct_pkg::DVW'(rm - {1'b0, s.dvs});
        s.quo = {s.quo[mfct_pkg::NW-2:0], 1'b1};
      end else begin
        s.rem = rm[mfct_pkg::DVW-1:0];
        s.quo = {s.quo[mfct_pkg::NW-2:0], 1'b0};
      end
      nx[ST_DIV+k] = s;
    end

    // path product
    s = st[ST_M4-1];
    case ({s.cmd, s.ser})
      {mfct_pkg::CMD_FWD, 1'b1}: begin
        s.pp = mfct_pkg::mul_pp(mfct_pkg::PW'(s.mag), s.fac);
        s.sh = mfct_pkg::SH_FRAC;
      end
      {mfct_pkg::CMD_FWD, 1'b0}: begin
        s.pp = mfct_pkg::mul_pp(mfct_pkg::PW'(s.zc), mfct_pkg::PW'(inverse_xi));
        s.sh = mfct_pkg::SH_ANGLE;
      end
      {mfct_pkg::CMD_INV, 1'b1}: begin
        s.pp = mfct_pkg::mul_pp(s.a, mfct_pkg::ONE + s.u2);
        s.sh = mfct_pkg::SH_FRAC;
      end
      default: begin
        s.pp = mfct_pkg::mul_pp(mfct_pkg::PW'(s.quo), mfct_pkg::PW'(inverse_xi));
        s.sh = mfct_pkg::SH_FRAC;
      end
    endcase
    nx[ST_M4]     = s;
    nx[ST_M4+1]   = st[ST_M4];
    mr            = mfct_pkg::mul_fin(st[ST_M4].pp, st[ST_M4].sh);
    nx[ST_M4+1].p = mr.val;
    nx[ST_M4+1].ovf = st[ST_M4].ovf | mr.ovf;

    // forward paths scale by 1/D1, inverse passes through
    nx[ST_M5]    = st[ST_M5-1];
    nx[ST_M5].pp = mfct_pkg::mul_pp(st[ST_M5-1].p,
                     (st[ST_M5-1].cmd == mfct_pkg::CMD_FWD) ?
                     mfct_pkg::PW'(inverse_d1) : mfct_pkg::ONE);
    nx[ST_M5].sh = mfct_pkg::SH_FRAC;
    nx[ST_M5+1]     = st[ST_M5];
    mr              = mfct_pkg::mul_fin(st[ST_M5].pp, st[ST_M5].sh);
    nx[ST_M5+1].r   = mr.val;
    nx[ST_M5+1].ovf = st[ST_M5].ovf | mr.ovf;

    // saturate and apply sign
    s   = st[ST_OUT-1];
    ng  = s.neg ^ s.flip;
    lim = ng ? (mfct_pkg::PW'(1) << 31) : ((mfct_pkg::PW'(1) << 31) - mfct_pkg::PW'(1));
    if (s.ovf || s.r > lim) begin
      s.r   = lim;
      s.err = 1'b1;
    end else begin
      s.err = 1'b0;
    end
    s.res = ng ? (32'(0) - s.r[31:0]) : s.r[31:0];
    nx[ST_OUT] = s;
  end

endmodule
